// ----- design/dafr_pkg.sv -----
// Shared constants, codes and types of the dual audio frame ring.
package dafr_pkg;

    // Default sizing
    localparam int CAPACITY_FRAMES_DEF = 1024;
    localparam int CHANNELS_DEF        = 2;

    // Fixed field widths
    localparam int SAMPLE_W      = 32;
    localparam int ACT_W         = 2;
    localparam int EP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int HELD_W        = 11;
    localparam int IN_TDATA_W    = 64;
    localparam int IN_TUSER_W    = 4;
    localparam int OUT_PAYLOAD_W = 2 * SAMPLE_W + HELD_W;
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = STATUS_W;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WRONG_DIR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Memory strobes from the pointer controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_op;

    // Per-request result, minus the read data
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HELD_W-1:0]   frames_held;
        logic                delivers;
    } t_result;

endpackage

// ----- design/dafr_ram.sv -----
// Generic single-clock RAM, one write and one registered read port.
module dafr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/dafr_ctrl.sv -----
// Pointer bank and request decode for both FIFOs; drives the frame store.
module dafr_ctrl import dafr_pkg::*; #(
    parameter int CAPACITY_FRAMES = CAPACITY_FRAMES_DEF,
    parameter int CHANNELS        = CHANNELS_DEF,
    localparam int SPAN   = 2 * CAPACITY_FRAMES,
    localparam int PTR_W  = $clog2(SPAN),
    localparam int DATA_W = SAMPLE_W * CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [EP_W-1:0]     i_endpoint,
    input  logic [SAMPLE_W-1:0] i_sample_ch0,
    input  logic [SAMPLE_W-1:0] i_sample_ch1,
    output t_mem_op             o_mem,
    output logic [PTR_W-1:0]    o_addr,
    output logic [DATA_W-1:0]   o_wdata,
    output t_result             o_res
);

    logic [PTR_W-1:0] r_wp [2];
    logic [PTR_W-1:0] r_rp [2];
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;

    logic             fifo_sel;
    logic             render;
    logic [PTR_W-1:0] cur_wp;
    logic [PTR_W-1:0] cur_rp;
    logic [PTR_W:0]   diff_wide;
    logic [PTR_W-1:0] held;
    logic [PTR_W-1:0] held_after;
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] acc_ptr;
    logic [PTR_W-1:0] slot;
    logic [2*SAMPLE_W-1:0] frame_word;
    t_mem_op          mem_op;
    logic [STATUS_W-1:0] status;
    logic             delivers;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(SPAN - 1)) ? '0 : p + 1'b1;
    endfunction

    // Addressed FIFO and its occupancy
    assign fifo_sel = i_endpoint[1];
    assign render   = ~i_endpoint[0];
    assign cur_wp   = r_wp[fifo_sel];
    assign cur_rp   = r_rp[fifo_sel];

    assign diff_wide = (cur_wp >= cur_rp)
                     ? {1'b0, cur_wp} - {1'b0, cur_rp}
                     : {1'b0, cur_wp} + (PTR_W+1)'(SPAN) - {1'b0, cur_rp};
    assign held  = diff_wide[PTR_W-1:0];
    assign full  = (held >= PTR_W'(CAPACITY_FRAMES));
    assign empty = (held == '0);

    // Store address: FIFO base plus slot of the pointer in use
    assign acc_ptr = (i_action == ACT_READ) ? cur_rp : cur_wp;
    assign slot    = (acc_ptr >= PTR_W'(CAPACITY_FRAMES))
                   ? acc_ptr - PTR_W'(CAPACITY_FRAMES) : acc_ptr;
    assign o_addr  = fifo_sel ? slot + PTR_W'(CAPACITY_FRAMES) : slot;

    assign frame_word = {i_sample_ch1, i_sample_ch0};
    assign o_wdata    = frame_word[DATA_W-1:0];

    // Request decode
    always_comb begin
        status     = ST_DONE;
        held_after = held;
        mem_op     = '0;
        delivers   = 1'b0;
        n_wp       = cur_wp;
        n_rp       = cur_rp;
        unique case (i_action)
            ACT_WRITE: begin
                if (!render) begin
                    status = ST_WRONG_DIR;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    mem_op.wr_en = 1'b1;
                    n_wp         = ptr_inc(cur_wp);
                    held_after   = held + 1'b1;
                end
            end
            ACT_READ: begin
                if (render) begin
                    status = ST_WRONG_DIR;
                end else if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    mem_op.rd_en = 1'b1;
                    delivers     = 1'b1;
                    n_rp         = ptr_inc(cur_rp);
                    held_after   = held - 1'b1;
                end
            end
            ACT_FLUSH: begin
                n_rp       = cur_wp;
                held_after = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_mem.wr_en       = mem_op.wr_en & i_fire;
    assign o_mem.rd_en       = mem_op.rd_en & i_fire;
    assign o_res.status      = status;
    assign o_res.frames_held = HELD_W'(held_after);
    assign o_res.delivers    = delivers;

    // Pointer update on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp[0] <= '0;
            r_wp[1] <= '0;
            r_rp[0] <= '0;
            r_rp[1] <= '0;
        end else if (i_fire) begin
            r_wp[fifo_sel] <= n_wp;
            r_rp[fifo_sel] <= n_rp;
        end
    end

endmodule

// ----- design/dual_audio_frame_ring.sv -----
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits on a stalled output; each request makes at most one access
// to the frame store, and its registered read feeds the result.
// Reset (synchronous, active low) zeroes all four pointers and the result
// valid; the frame store is not cleared and needs no clearing pass.
// Input ready falls only while a finished result waits on the output.
module dual_audio_frame_ring import dafr_pkg::*; #(
    parameter int CAPACITY_FRAMES = CAPACITY_FRAMES_DEF,
    parameter int CHANNELS        = CHANNELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // sample_ch0 [31:0], sample_ch1 [63:32]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // action [1:0], endpoint [3:2]
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // out_ch0 [31:0], out_ch1 [63:32], frames_held [74:64], zero [79:75]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status [1:0]
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int SPAN   = 2 * CAPACITY_FRAMES;
    localparam int PTR_W  = $clog2(SPAN);
    localparam int DATA_W = SAMPLE_W * CHANNELS;

    logic                in_fire;
    logic                out_fire;
    t_mem_op             mem_op;
    logic [PTR_W-1:0]    mem_addr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [DATA_W-1:0]   mem_rdata;
    logic [2*SAMPLE_W-1:0] rd_word;
    t_result             res;
    t_result             r_res;
    logic                r_out_valid;
    logic                n_out_valid;

    assign in_fire  = i_s_axis_tvalid & o_s_axis_tready;
    assign out_fire = r_out_valid & i_m_axis_tready;
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;

    dafr_ctrl #(
        .CAPACITY_FRAMES (CAPACITY_FRAMES),
        .CHANNELS        (CHANNELS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_action     (i_s_axis_tuser[ACT_W-1:0]),
        .i_endpoint   (i_s_axis_tuser[ACT_W+EP_W-1:ACT_W]),
        .i_sample_ch0 (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_sample_ch1 (i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .o_mem        (mem_op),
        .o_addr       (mem_addr),
        .o_wdata      (mem_wdata),
        .o_res        (res)
    );

    dafr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SPAN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_op.wr_en),
        .i_wr_addr (mem_addr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_op.rd_en),
        .i_rd_addr (mem_addr),
        .o_rd_data (mem_rdata)
    );

    // Result register; read data sits in the store's output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_fire) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= res;
        end
    end

    // Output packing; a single-channel store leaves channel 1 zero
    assign rd_word         = (2*SAMPLE_W)'(mem_rdata);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_res.status;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_PAYLOAD_W)'(0), r_res.frames_held,
                              r_res.delivers ? rd_word : {(2*SAMPLE_W){1'b0}}};

`ifndef SYNTHESIS
    // A write refused as full reports the capacity as its frame count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res.status == ST_FULL |-> res.frames_held == HELD_W'(CAPACITY_FRAMES))
        else $error("full status without a full count");

    // A flush leaves the FIFO empty in its result
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_s_axis_tuser[ACT_W-1:0] == ACT_FLUSH |=>
        o_m_axis_tvalid && o_m_axis_tdata[2*SAMPLE_W+HELD_W-1:2*SAMPLE_W] == '0)
        else $error("flush result not empty");

    // Only a delivering read puts sample data on the output
    a_zero_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_DONE |-> o_m_axis_tdata[2*SAMPLE_W-1:0] == '0)
        else $error("sample data on a failed request");

    // Input never stalls while the result register is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with no result waiting");
`endif

endmodule
